// ===== src/smas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package smas_pkg;

	// item kinds
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_MIX   = 2'd1;
	localparam logic [1:0] ACT_DRAIN = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MVOL = 2'd0;
	localparam logic [1:0] REG_FMT  = 2'd1;
	localparam logic [1:0] REG_CHAN = 2'd2;

	localparam int APB_AW = 4;
	localparam int SLOT_W = 11;
	localparam int SLOT_SPAN = 2048;

	localparam logic [9:0] MVOL_MAX   = 10'd512;
	localparam logic [9:0] MVOL_RESET = 10'd256;
	localparam logic [1:0] CHAN_MONO   = 2'd1;
	localparam logic [1:0] CHAN_RESET  = 2'd2;

	localparam logic signed [23:0] SAT_HI = 24'sd32767;
	localparam logic signed [23:0] SAT_LO = -24'sd32768;
	localparam logic [15:0] OUT_MAX = 16'h7fff;
	localparam logic [15:0] OUT_MIN = 16'h8000;
	localparam logic [7:0] U8_BIAS = 8'd128;

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] l;
	} acc_pair_t;

	typedef struct packed {
		logic               en;
		logic signed [16:0] a;
		logic signed [18:0] b;
	} mul_op_t;

endpackage

`default_nettype wire

// ===== src/smas_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smas_mul
	import smas_pkg::*;
(
	input  wire logic               clk,
	input  wire mul_op_t            op,
	output      logic signed [35:0] prod_q
);

	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= 36'(op.a * op.b);
		end
	end

endmodule

`default_nettype wire

// ===== src/smas_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module smas_store
	import smas_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              wr,
	input  wire logic              rd,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire acc_pair_t         wdata,
	output      acc_pair_t         rdata_q
);

	acc_pair_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/stereo_mix_accumulator_saturating_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stereo mix accumulator: a store of MIX_DEPTH left/right 32-bit accumulators that wrap.
// A clear item zeroes a slot, a mix item adds a volume-scaled sample to both sides of a
// slot, a drain item returns the slot shifted down by 8 and clamped to signed 16 bits
// (or biased unsigned 8 bits, mono or stereo per the config registers). Items are taken
// one at a time. Every clear, mix or drain item first reduces its slot index modulo
// MIX_DEPTH by compare-subtract steps in ST_RED, after the accept; a clear then
// finishes, a drain reads the store and waits in ST_DRN for the output register, and a
// mix steps through ST_MGL, ST_MSL, ST_ADL, ST_MGR, ST_MSR and ST_ADR: one shared
// multiplier forms vol*master and then sample*gain for each side in turn, and one adder
// updates each side before the write-back. A finished drain result sits in an output
// register, so the next item is taken while it waits; a second drain waits there only if
// that register is still full. Never-cleared slots read back as garbage.
module stereo_mix_accumulator_saturating_core
	import smas_pkg::*;
#(
	parameter int MIX_DEPTH = 2048
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// slave stream
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [47:0]       s_tdata,  // slot[10:0], sample[26:11], left_volume[34:27],
	                                         // right_volume[42:35], zero pad
	input  wire logic [2:0]        s_tuser,  // action[1:0], sample_is_8bit[2]
	// master stream
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [31:0]       m_tdata,  // out_left[15:0], out_right[31:16]
	// config
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output      logic [31:0]       prdata,
	output      logic              pready
);

	localparam int ADDR_W = (MIX_DEPTH > 1) ? $clog2(MIX_DEPTH) : 1;
	localparam int RED_K = $clog2(SLOT_SPAN / MIX_DEPTH + 1);
	localparam int K_W = (RED_K > 0) ? $clog2(RED_K + 1) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RED  = 4'd1;
	localparam logic [3:0] ST_MGL  = 4'd2;
	localparam logic [3:0] ST_MSL  = 4'd3;
	localparam logic [3:0] ST_ADL  = 4'd4;
	localparam logic [3:0] ST_MGR  = 4'd5;
	localparam logic [3:0] ST_MSR  = 4'd6;
	localparam logic [3:0] ST_ADR  = 4'd7;
	localparam logic [3:0] ST_DRN  = 4'd8;

	logic [3:0]         state_q;
	logic [K_W-1:0]     k_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [1:0]         act_q;
	logic               is8_q;
	logic signed [16:0] smp_q;
	logic [7:0]         vl_q;
	logic [7:0]         vr_q;
	logic [31:0]        accl_q;

	logic [9:0]  mvol_q;
	logic        fmt_q;
	logic [1:0]  chan_q;

	logic        out_vld_q;
	logic [15:0] out_l_q;
	logic [15:0] out_r_q;

	logic              s_acc;
	logic              cfg_wr;
	logic [9:0]        mv;
	logic [31:0]       step_val;
	logic              red_hit;
	logic [SLOT_W-1:0] idx_nx;
	logic              mem_wr;
	logic              mem_rd;
	logic [ADDR_W-1:0] mem_addr;
	acc_pair_t         mem_wdata;
	acc_pair_t         mem_rdata;
	mul_op_t           mul_op;
	logic signed [35:0] prod_q;
	logic [7:0]        vol_sel;
	logic [7:0]        vol_x;
	logic [31:0]       amt;
	logic [31:0]       sum;
	logic              out_load;
	logic [15:0]       drn_l;
	logic [15:0]       drn_r;

	function automatic logic [15:0] drain_side(input logic [31:0] acc, input logic fmt8);
		logic signed [23:0] v;
		logic [15:0]        c;
		v = $signed(acc[31:8]);
		if (v > SAT_HI) begin
			c = OUT_MAX;
		end else if (v < SAT_LO) begin
			c = OUT_MIN;
		end else begin
			c = v[15:0];
		end
		if (fmt8) begin
			return {8'h00, c[15:8] + U8_BIAS};
		end
		return c;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid & s_tready;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign mv = (mvol_q > MVOL_MAX) ? MVOL_MAX : mvol_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvol_q <= MVOL_RESET;
			fmt_q <= 1'b0;
			chan_q <= CHAN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MVOL: mvol_q <= pwdata[9:0];
				REG_FMT:  fmt_q <= pwdata[0];
				REG_CHAN: chan_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MVOL: prdata = {22'd0, mvol_q};
			REG_FMT:  prdata = {31'd0, fmt_q};
			REG_CHAN: prdata = {30'd0, chan_q};
			default:  prdata = 32'd0;
		endcase
	end

	// slot index modulo depth, one compare-subtract per cycle
	assign step_val = 32'(MIX_DEPTH) << k_q;
	assign red_hit = {{(32 - SLOT_W){1'b0}}, idx_q} >= step_val;
	assign idx_nx = red_hit ? idx_q - step_val[SLOT_W-1:0] : idx_q;

	// shared multiplier operands
	assign vol_sel = (state_q == ST_MGL) ? vl_q : vr_q;
	assign vol_x = is8_q ? {vol_sel[7:3], 3'b000} : vol_sel;

	always_comb begin
		mul_op.en = 1'b0;
		mul_op.a = '0;
		mul_op.b = '0;
		unique case (state_q)
			ST_MGL, ST_MGR: begin
				mul_op.en = 1'b1;
				mul_op.a = $signed({9'd0, vol_x});
				mul_op.b = $signed({9'd0, mv});
			end
			ST_MSL, ST_MSR: begin
				mul_op.en = 1'b1;
				mul_op.a = smp_q;
				mul_op.b = $signed({1'b0, prod_q[17:0]});
			end
			default: ;
		endcase
	end

	smas_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	// 16-bit samples drop 8 fraction bits with floor
	assign amt = is8_q ? prod_q[31:0] : {{4{prod_q[35]}}, prod_q[35:8]};
	assign sum = ((state_q == ST_ADL) ? mem_rdata.l : mem_rdata.r) + amt;

	always_comb begin
		mem_wr = 1'b0;
		mem_rd = 1'b0;
		mem_addr = ADDR_W'(idx_q);
		mem_wdata.l = accl_q;
		mem_wdata.r = sum;
		if (state_q == ST_RED && k_q == '0) begin
			mem_addr = ADDR_W'(idx_nx);
			mem_wr = (act_q == ACT_CLEAR);
			mem_rd = (act_q != ACT_CLEAR);
			if (act_q == ACT_CLEAR) begin
				mem_wdata.l = '0;
				mem_wdata.r = '0;
			end
		end else if (state_q == ST_ADR) begin
			mem_wr = 1'b1;
		end
	end

	smas_store #(
		.DEPTH  (MIX_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr      (mem_wr),
		.rd      (mem_rd),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata_q (mem_rdata)
	);

	// item capture and payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			act_q <= s_tuser[1:0];
			is8_q <= s_tuser[2];
			idx_q <= s_tdata[10:0];
			smp_q <= s_tuser[2] ? 17'($signed(s_tdata[18:11])) : 17'($signed(s_tdata[26:11]));
			vl_q <= s_tdata[34:27];
			vr_q <= s_tdata[42:35];
		end else if (state_q == ST_RED) begin
			idx_q <= idx_nx;
		end
		if (state_q == ST_ADL) begin
			accl_q <= sum;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser[1:0] == ACT_CLEAR || s_tuser[1:0] == ACT_MIX ||
					              s_tuser[1:0] == ACT_DRAIN)) begin
						state_q <= ST_RED;
						k_q <= K_W'(RED_K);
					end
				end
				ST_RED: begin
					if (k_q == '0) begin
						if (act_q == ACT_MIX) begin
							state_q <= ST_MGL;
						end else if (act_q == ACT_DRAIN) begin
							state_q <= ST_DRN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_MGL: state_q <= ST_MSL;
				ST_MSL: state_q <= ST_ADL;
				ST_ADL: state_q <= ST_MGR;
				ST_MGR: state_q <= ST_MSR;
				ST_MSR: state_q <= ST_ADR;
				ST_ADR: state_q <= ST_IDLE;
				ST_DRN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// drain result register
	assign out_load = (state_q == ST_DRN) && (!out_vld_q || m_tready);
	assign drn_l = drain_side(mem_rdata.l, fmt_q);
	assign drn_r = (chan_q == CHAN_MONO) ? 16'd0 : drain_side(mem_rdata.r, fmt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_l_q <= drn_l;
			out_r_q <= drn_r;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {out_r_q, out_l_q};

	a_wr_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> (state_q == ST_RED || state_q == ST_ADR))
		else $error("store written outside clear or write-back");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr || mem_rd) |-> (32'(mem_addr) < MIX_DEPTH))
		else $error("slot index not reduced below depth");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DRN)
		else $error("result raised without a drain");

	a_adr_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADR) |-> (act_q == ACT_MIX))
		else $error("write-back for a non-mix item");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import smas_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 24;
	localparam int LIMIT_CYCLES = 600000;

	typedef struct packed {
		logic [1:0]        action;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       sample;
		logic              is8;
		logic [7:0]        left_volume;
		logic [7:0]        right_volume;
	} mix_item_t;

	typedef struct packed {
		logic [15:0] right;
		logic [15:0] left;
	} mix_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;  // slot, sample, left_volume, right_volume, zero pad
	logic [2:0] s_tuser = '0;   // action, sample_is_8bit
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;       // out_left, out_right
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	acc_pair_t mixed_sums[SLOT_SPAN];
	bit slot_live[SLOT_SPAN];
	logic [9:0] cfg_mvol = MVOL_RESET;
	logic cfg_fmt = 1'b0;
	logic [1:0] cfg_chan = CHAN_RESET;

	mix_out_t pending_drains[$];
	bit steady_flow = 1'b0;
	int err_count = 0;
	int n_items = 0;
	int n_mixes = 0;
	int n_clears = 0;
	int n_checked = 0;
	int n_settings = 0;

	stereo_mix_accumulator_saturating_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	task automatic report_err(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [31:0] mix_amount(input logic [15:0] smp, input logic is8,
			input logic [7:0] vol);
		longint s, v, mv, amt;
		v = vol;
		mv = (cfg_mvol > MVOL_MAX) ? MVOL_MAX : cfg_mvol;
		if (is8) begin
			// only the low byte counts, volume loses its low three bits
			s = $signed(smp[7:0]);
			amt = s * ((v >> 3) * 8 * mv);
		end else begin
			s = $signed(smp);
			amt = (s * v * mv) >>> 8;
		end
		return amt[31:0];
	endfunction

	function automatic logic [15:0] drain_side(input logic [31:0] acc);
		longint v;
		v = $signed(acc);
		v = v >>> 8;
		if (v > SAT_HI)
			v = SAT_HI;
		else if (v < SAT_LO)
			v = SAT_LO;
		if (cfg_fmt) begin
			v = v >>> 8;
			v = v + U8_BIAS;
		end
		return v[15:0];
	endfunction

	task automatic apply_to_mix_store(input mix_item_t it);
		mix_out_t o;
		case (it.action)
		ACT_CLEAR: begin
			mixed_sums[it.slot] = '0;
			slot_live[it.slot] = 1'b1;
			n_clears++;
		end
		ACT_MIX: begin
			mixed_sums[it.slot].l += mix_amount(it.sample, it.is8, it.left_volume);
			mixed_sums[it.slot].r += mix_amount(it.sample, it.is8, it.right_volume);
			n_mixes++;
		end
		ACT_DRAIN: begin
			o.left = drain_side(mixed_sums[it.slot].l);
			o.right = (cfg_chan == CHAN_MONO) ? 16'd0 : drain_side(mixed_sums[it.slot].r);
			pending_drains.push_back(o);
		end
		default: ;
		endcase
	endtask

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_item(input mix_item_t it);
		while (!steady_flow && $urandom_range(99) < 22) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {5'd0, it.right_volume, it.left_volume, it.sample, it.slot};
		s_tuser = {it.is8, it.action};
		do @(posedge clk); while (!s_tready);
		apply_to_mix_store(it);
		n_items++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		while (pending_drains.size() != 0)
			@(negedge clk);
		// clears and mixes may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] got;
		apb_access(1'b0, idx, 32'd0, got);
		if (got !== want)
			report_err($sformatf("register %0d reads %0h, want %0h", idx, got, want));
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] unused;
		logic [31:0] want;
		apb_access(1'b1, idx, val, unused);
		case (idx)
		REG_MVOL: cfg_mvol = val[9:0];
		REG_FMT:  cfg_fmt = val[0];
		REG_CHAN: cfg_chan = val[1:0];
		default: ;
		endcase
		want = (idx == REG_MVOL) ? {22'd0, cfg_mvol} :
			(idx == REG_FMT) ? {31'd0, cfg_fmt} : {30'd0, cfg_chan};
		check_reg(idx, want);
	endtask

	task automatic set_mode(input int mv, input int fmt, input int chan);
		set_reg(REG_MVOL, mv);
		set_reg(REG_FMT, fmt);
		set_reg(REG_CHAN, chan);
		n_settings++;
	endtask

	function automatic mix_item_t mk_item(input logic [1:0] a, input int slot,
			input logic [15:0] smp, input logic is8, input logic [7:0] lv, input logic [7:0] rv);
		mix_item_t it;
		it.action = a;
		it.slot = slot;
		it.sample = smp;
		it.is8 = is8;
		it.left_volume = lv;
		it.right_volume = rv;
		return it;
	endfunction

	function automatic mix_item_t random_item();
		mix_item_t it;
		int roll;
		roll = $urandom_range(99);
		it.action = (roll < 10) ? ACT_CLEAR : (roll < 65) ? ACT_MIX :
			(roll < 95) ? ACT_DRAIN : ACT_NONE;
		// mostly a few hot slots so mixes pile up before a drain
		it.slot = ($urandom_range(99) < 75) ? $urandom_range(15) : $urandom_range(SLOT_SPAN - 1);
		if ((it.action == ACT_MIX || it.action == ACT_DRAIN) && !slot_live[it.slot])
			it.action = ACT_CLEAR;
		roll = $urandom_range(99);
		if (roll < 35)
			it.sample = $urandom_range(16'hffff);
		else if (roll < 75)
			it.sample = $urandom_range(1023) - 512;
		else begin
			case ($urandom_range(3))
			0: it.sample = 16'h7fff;
			1: it.sample = 16'h8000;
			2: it.sample = 16'hffff;
			default: it.sample = 16'h0000;
			endcase
		end
		it.is8 = $urandom_range(1);
		it.left_volume = ($urandom_range(1) != 0) ? $urandom_range(255) : $urandom_range(15);
		it.right_volume = ($urandom_range(1) != 0) ? $urandom_range(255) : $urandom_range(15);
		return it;
	endfunction

	always @(negedge clk)
		m_tready = steady_flow || ($urandom_range(99) >= 22);

	always @(posedge clk) begin
		mix_out_t want;
		mix_out_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_drains.size() == 0) begin
				report_err($sformatf("unexpected drain word %08h", m_tdata));
			end else begin
				want = pending_drains.pop_front();
				n_checked++;
				if (got.left !== want.left)
					report_err($sformatf("out_left %04h, want %04h", got.left, want.left));
				if (got.right !== want.right)
					report_err($sformatf("out_right %04h, want %04h", got.right, want.right));
			end
		end
	end

	task automatic test_reset_values();
		check_reg(REG_MVOL, MVOL_RESET);
		check_reg(REG_FMT, 32'd0);
		check_reg(REG_CHAN, CHAN_RESET);
	endtask

	task automatic test_directed_edges();
		// full-scale 16-bit mixes at both signs, one side silent
		send_item(mk_item(ACT_CLEAR, 0, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_CLEAR, SLOT_SPAN - 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_CLEAR, 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_MIX, 0, 16'h7fff, 1'b0, 8'd255, 8'd0));
		send_item(mk_item(ACT_MIX, SLOT_SPAN - 1, 16'h8000, 1'b0, 8'd255, 8'd255));
		// byte samples: volume below 8 drops to zero, wide sample keeps its low byte
		send_item(mk_item(ACT_MIX, 1, 16'h007f, 1'b1, 8'd255, 8'd7));
		send_item(mk_item(ACT_MIX, 1, 16'hab80, 1'b1, 8'd248, 8'd255));
		send_item(mk_item(ACT_DRAIN, 0, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_DRAIN, SLOT_SPAN - 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_DRAIN, 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		// unknown action on a slot never written
		send_item(mk_item(ACT_NONE, 1234, 16'hffff, 1'b1, 8'd255, 8'd255));
		// tiny amounts, floor of negative products
		send_item(mk_item(ACT_CLEAR, 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_MIX, 1, 16'h0001, 1'b0, 8'd1, 8'd1));
		send_item(mk_item(ACT_MIX, 1, 16'hffff, 1'b0, 8'd1, 8'd1));
		send_item(mk_item(ACT_MIX, 1, 16'hffff, 1'b0, 8'd3, 8'd0));
		send_item(mk_item(ACT_DRAIN, 1, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_CLEAR, 0, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_MIX, 0, 16'h1234, 1'b0, 8'd128, 8'd64));
		send_item(mk_item(ACT_MIX, 0, 16'h00c3, 1'b1, 8'd17, 8'd200));
		send_item(mk_item(ACT_DRAIN, 0, 16'h0000, 1'b0, 8'd0, 8'd0));
		send_item(mk_item(ACT_DRAIN, 0, 16'h0000, 1'b0, 8'd0, 8'd0));
		settle();
	endtask

	task automatic test_register_sweep();
		int mv_set[7] = '{0, 512, 1023, 513, 1, 300, 256};
		int fmt_set[7] = '{0, 1, 0, 1, 0, 1, 0};
		int chan_set[7] = '{2, 1, 3, 0, 1, 2, 2};
		mix_item_t it;
		for (int k = 0; k < 7; k++) begin
			set_mode(mv_set[k], fmt_set[k], chan_set[k]);
			for (int n = 0; n < 60; n++) begin
				it = random_item();
				send_item(it);
			end
			settle();
		end
	endtask

	task automatic test_random_traffic();
		mix_item_t it;
		int done;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			set_mode(($urandom_range(3) == 0) ? $urandom_range(513, 1023) : $urandom_range(512),
				$urandom_range(1), $urandom_range(3));
			steady_flow = (ph == 2);
			done = 0;
			while (done < 400) begin
				it = random_item();
				send_item(it);
				if (it.action != ACT_NONE) begin
					done++;
					// hold the sender until every drain is back
					if (ph == 0 && done == 200)
						settle();
				end
			end
		end
		steady_flow = 1'b0;
		settle();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_directed_edges();
		test_register_sweep();
		test_random_traffic();
		$display("ran %0d items: %0d clears, %0d mixes, %0d drain words checked",
			n_items, n_clears, n_mixes, n_checked);
		$display("register settings used: %0d, mismatches: %0d", n_settings, err_count);
		if (err_count == 0)
			$display("stereo_mix_accumulator_saturating_core regression: pass");
		else
			$display("stereo_mix_accumulator_saturating_core regression: fail");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 4);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("stereo_mix_accumulator_saturating_core regression: fail");
		$finish;
	end

endmodule
